// ----- rtl/slipcrc_pkg.sv -----
// ----------------------------------------------------------------------------
// slipcrc_pkg
// Shared types, SLIP codes and CRC-16/CCITT-FALSE helpers for the frame
// encoder.
// ----------------------------------------------------------------------------
package slipcrc_pkg;

  // slip codes
  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  // crc constants
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  // largest burst one input byte can cause
  localparam int unsigned BurstLen = 8;
  localparam int unsigned IdxW     = $clog2(BurstLen);
  localparam int unsigned CntW     = IdxW + 1;

  // one escaped byte: one or two line bytes
  typedef struct packed {
    logic       pair;
    logic [7:0] first;
    logic [7:0] second;
  } esc_t;

  // encoded bytes for one input transaction
  typedef struct packed {
    logic [BurstLen-1:0][7:0] bytes;
    logic [IdxW-1:0]          last_idx;
    logic                     close;
  } burst_t;

  // one byte into the running crc, msb first
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // slip escape of a single byte
  function automatic esc_t slip_escape(logic [7:0] b);
    esc_t e;
    e.pair   = 1'b0;
    e.first  = b;
    e.second = SLIP_ESC_END;
    if (b == SLIP_END) begin
      e.pair   = 1'b1;
      e.first  = SLIP_ESC;
      e.second = SLIP_ESC_END;
    end else if (b == SLIP_ESC) begin
      e.pair   = 1'b1;
      e.first  = SLIP_ESC;
      e.second = SLIP_ESC_ESC;
    end
    return e;
  endfunction

endpackage

// ----- rtl/slipcrc_in_if.sv -----
// ----------------------------------------------------------------------------
// slipcrc_in_if
// Raw packet byte channel: valid/ready with byte and last-byte flag.
// ----------------------------------------------------------------------------
interface slipcrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/slipcrc_out_if.sv -----
// ----------------------------------------------------------------------------
// slipcrc_out_if
// Encoded line byte channel: valid/ready with byte and framing flags.
// ----------------------------------------------------------------------------
interface slipcrc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_close;

  modport source (output valid, output out_byte, output run_last,
                  output frame_close, input ready);
  modport sink   (input valid, input out_byte, input run_last,
                  input frame_close, output ready);
endinterface

// ----- rtl/slip_crc_frame_encoder.sv -----
// Each accepted packet byte is registered, then expanded in one pass into
// its whole run of line bytes (opening END, escaped byte, and for the last
// byte the escaped CRC-16/CCITT-FALSE low then high byte and a closing
// END), which leave one per cycle while the line is ready. An input byte
// gives 1 to 8 line bytes: one for a plain byte inside a frame, two for
// an escaped one, plus one for a frame's opening END and three to five
// for the trailer. The serializer sets the rate; the next byte is expanded
// while the last line byte of the previous one is taken, so the line is
// never left idle when input is waiting. With the serializer free, the
// input and burst registers lie between acceptance and first line byte.
// ----------------------------------------------------------------------------
// slip_crc_frame_encoder
// SLIP framer with a CRC-16/CCITT-FALSE trailer on each packet.
// ----------------------------------------------------------------------------
module slip_crc_frame_encoder
  import slipcrc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  slipcrc_in_if.sink    in_i,
  slipcrc_out_if.source out_o
);

  logic       in_valid_q;
  logic [7:0] in_data_q;
  logic       in_last_q;
  logic       load;
  logic       free;
  burst_t     burst;

  // hand the held byte to the burst register when it frees up
  assign load       = in_valid_q && free;
  assign in_i.ready = !in_valid_q || load;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_data_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  // expansion and frame state
  slipcrc_encode u_encode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .data_i  (in_data_q),
    .last_i  (in_last_q),
    .burst_o (burst)
  );

  // byte serializer
  slipcrc_serial u_serial (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .burst_i (burst),
    .free_o  (free),
    .out_o   (out_o)
  );

endmodule

// ----- rtl/slipcrc_encode.sv -----
// ----------------------------------------------------------------------------
// slipcrc_encode
// Builds the full burst of line bytes for one packet byte and holds the
// frame-open flag and running crc.
// ----------------------------------------------------------------------------
module slipcrc_encode
  import slipcrc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  logic [7:0] data_i,
  input  logic       last_i,
  output burst_t     burst_o
);

  logic        frame_open_q, frame_open_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_next;

  assign crc_next = crc_feed(crc_q, data_i);

  // burst assembly: opening end, escaped byte, crc trailer, closing end
  always_comb begin
    logic [CntW-1:0] n;
    logic [CntW-1:0] n_m1;
    esc_t            e;
    burst_o.bytes = '{default: SLIP_END};
    burst_o.close = last_i;
    n             = '0;
    if (!frame_open_q) begin
      burst_o.bytes[n[IdxW-1:0]] = SLIP_END;
      n = n + 1'b1;
    end
    e = slip_escape(data_i);
    burst_o.bytes[n[IdxW-1:0]] = e.first;
    n = n + 1'b1;
    if (e.pair) begin
      burst_o.bytes[n[IdxW-1:0]] = e.second;
      n = n + 1'b1;
    end
    if (last_i) begin
      e = slip_escape(crc_next[7:0]);
      burst_o.bytes[n[IdxW-1:0]] = e.first;
      n = n + 1'b1;
      if (e.pair) begin
        burst_o.bytes[n[IdxW-1:0]] = e.second;
        n = n + 1'b1;
      end
      e = slip_escape(crc_next[15:8]);
      burst_o.bytes[n[IdxW-1:0]] = e.first;
      n = n + 1'b1;
      if (e.pair) begin
        burst_o.bytes[n[IdxW-1:0]] = e.second;
        n = n + 1'b1;
      end
      burst_o.bytes[n[IdxW-1:0]] = SLIP_END;
      n = n + 1'b1;
    end
    n_m1 = n - 1'b1;
    burst_o.last_idx = n_m1[IdxW-1:0];
  end

  // frame state update on each loaded transaction
  always_comb begin
    frame_open_d = frame_open_q;
    crc_d        = crc_q;
    if (load_i) begin
      if (last_i) begin
        frame_open_d = 1'b0;
        crc_d        = CRC_INIT;
      end else begin
        frame_open_d = 1'b1;
        crc_d        = crc_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      crc_q        <= CRC_INIT;
    end else begin
      frame_open_q <= frame_open_d;
      crc_q        <= crc_d;
    end
  end

endmodule

// ----- rtl/slipcrc_serial.sv -----
// ----------------------------------------------------------------------------
// slipcrc_serial
// Burst register that hands encoded bytes to the line one per transaction.
// ----------------------------------------------------------------------------
module slipcrc_serial
  import slipcrc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  burst_t               burst_i,
  output logic                 free_o,
  slipcrc_out_if.source        out_o
);

  burst_t          burst_q;
  logic            valid_q, valid_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            at_end;
  logic            out_fire;

  assign at_end   = (idx_q == burst_q.last_idx);
  assign out_fire = out_o.valid && out_o.ready;
  assign free_o   = !valid_q || (out_fire && at_end);

  // output view of the current byte
  assign out_o.valid       = valid_q;
  assign out_o.out_byte    = burst_q.bytes[idx_q];
  assign out_o.run_last    = at_end;
  assign out_o.frame_close = at_end && burst_q.close;

  // byte pointer and burst occupancy
  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (out_fire) begin
      if (at_end) begin
        valid_d = 1'b0;
        idx_d   = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // burst payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives packet bytes into the SLIP frame encoder and checks every line byte
// against a CRC-16/CCITT-FALSE framing predictor. Covers the escape codes,
// the CRC trailer and random frames, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import slipcrc_pkg::*;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned RandomItems = 330;

  // one line byte as the block should produce it
  typedef struct {
    logic [7:0] value;
    logic       run_last;
    logic       frame_close;
  } line_byte_t;

  logic clk_i;
  logic rst_ni;

  slipcrc_in_if  pkt_if ();
  slipcrc_out_if line_if ();

  slip_crc_frame_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pkt_if),
    .out_o  (line_if)
  );

  // framing state of the predictor
  logic        pred_frame_open;
  logic [15:0] pred_crc;
  line_byte_t  line_expect_q[$];

  int unsigned mismatch_count;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;
  bit          send_idle_on;
  bit          line_idle_on;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_gap(bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // crc-16/ccitt-false, one message bit at a time
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return crc;
  endfunction

  function automatic void push_line_byte(logic [7:0] value, logic close);
    line_byte_t lb;
    lb.value       = value;
    lb.run_last    = 1'b0;
    lb.frame_close = close;
    line_expect_q.push_back(lb);
  endfunction

  function automatic void push_escaped(logic [7:0] b);
    if (b == SLIP_END) begin
      push_line_byte(SLIP_ESC, 1'b0);
      push_line_byte(SLIP_ESC_END, 1'b0);
    end else if (b == SLIP_ESC) begin
      push_line_byte(SLIP_ESC, 1'b0);
      push_line_byte(SLIP_ESC_ESC, 1'b0);
    end else begin
      push_line_byte(b, 1'b0);
    end
  endfunction

  // line bytes caused by one packet byte, updates frame state
  function automatic void predict_encoding(logic [7:0] d, logic last);
    if (!pred_frame_open) begin
      push_line_byte(SLIP_END, 1'b0);
      pred_frame_open = 1'b1;
    end
    push_escaped(d);
    pred_crc = crc16_step(pred_crc, d);
    if (last) begin
      push_escaped(pred_crc[7:0]);
      push_escaped(pred_crc[15:8]);
      push_line_byte(SLIP_END, 1'b1);
      pred_crc        = CRC_INIT;
      pred_frame_open = 1'b0;
    end
    line_expect_q[line_expect_q.size() - 1].run_last = 1'b1;
  endfunction

  // send one packet byte, predict once the transaction is taken
  task automatic send_packet_byte(logic [7:0] d, logic last);
    int unsigned gap;
    gap = idle_gap(send_idle_on);
    if (gap > 0) begin
      pkt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pkt_if.valid     <= 1'b1;
    pkt_if.data_byte <= d;
    pkt_if.last_byte <= last;
    do @(posedge clk_i); while (!(pkt_if.valid && pkt_if.ready));
    predict_encoding(d, last);
    bytes_sent++;
  endtask

  // random payload byte, biased toward the slip codes
  function automatic logic [7:0] random_payload();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return SLIP_END;
    if (r < 24) return SLIP_ESC;
    if (r < 28) return SLIP_ESC_END;
    if (r < 32) return SLIP_ESC_ESC;
    return 8'($urandom_range(0, 255));
  endfunction

  // one whole packet of random length and content
  task automatic send_random_packet();
    int unsigned len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    for (int unsigned i = 1; i <= len; i++) begin
      send_packet_byte(random_payload(), i == len);
    end
  endtask

  // ready on the line side: runs of ready with random stalls
  initial begin
    int unsigned run;
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      run = $urandom_range(1, 12);
      line_if.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = idle_gap(line_idle_on);
      if (gap > 0) begin
        line_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // compare each line transaction with the oldest expectation
  always @(posedge clk_i) begin
    line_byte_t want;
    if (rst_ni && line_if.valid && line_if.ready) begin
      if (line_expect_q.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("[%0t] unexpected line byte %h run_last %b frame_close %b", $realtime,
                   line_if.out_byte, line_if.run_last, line_if.frame_close);
        end
        mismatch_count++;
      end else begin
        want = line_expect_q.pop_front();
        if (line_if.out_byte !== want.value || line_if.run_last !== want.run_last ||
            line_if.frame_close !== want.frame_close) begin
          if (mismatch_count < 10) begin
            $display("[%0t] line byte mismatch: exp %h/%b/%b got %h/%b/%b", $realtime,
                     want.value, want.run_last, want.frame_close,
                     line_if.out_byte, line_if.run_last, line_if.frame_close);
          end
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (pkt_if.valid && pkt_if.ready) || (line_if.valid && line_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, QuietLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // single-byte packets at the byte extremes and on every slip code
  task automatic test_escape_codes();
    send_packet_byte(8'h00, 1'b1);
    send_packet_byte(8'hFF, 1'b1);
    send_packet_byte(SLIP_END, 1'b1);
    send_packet_byte(SLIP_ESC, 1'b1);
    send_packet_byte(SLIP_ESC_END, 1'b1);
    send_packet_byte(SLIP_ESC_ESC, 1'b1);
  endtask

  // multi-byte frame: opening end once, crc over the whole packet
  task automatic test_multi_byte_frame();
    send_packet_byte(8'h00, 1'b0);
    send_packet_byte(8'hFF, 1'b0);
    send_packet_byte(SLIP_END, 1'b0);
    send_packet_byte(SLIP_ESC, 1'b0);
    send_packet_byte(8'hAA, 1'b0);
    send_packet_byte(8'h55, 1'b1);
  endtask

  // crc halves that need escaping, and the longest single-byte burst
  task automatic test_crc_trailer();
    logic [15:0] c;
    int          lo_pick;
    int          hi_pick;
    int          best_pick;
    int unsigned best_len;
    int unsigned len;
    lo_pick   = -1;
    hi_pick   = -1;
    best_pick = 0;
    best_len  = 0;
    for (int b = 0; b < 256; b++) begin
      c   = crc16_step(CRC_INIT, 8'(b));
      len = 5;
      if (8'(b) == SLIP_END || 8'(b) == SLIP_ESC) len++;
      if (c[7:0] == SLIP_END || c[7:0] == SLIP_ESC) begin
        len++;
        if (lo_pick < 0) lo_pick = b;
      end
      if (c[15:8] == SLIP_END || c[15:8] == SLIP_ESC) begin
        len++;
        if (hi_pick < 0) hi_pick = b;
      end
      if (len > best_len) begin
        best_len  = len;
        best_pick = b;
      end
    end
    if (lo_pick >= 0) send_packet_byte(8'(lo_pick), 1'b1);
    if (hi_pick >= 0) send_packet_byte(8'(hi_pick), 1'b1);
    send_packet_byte(8'(best_pick), 1'b1);
  endtask

  // random frames with random idling on both sides
  task automatic test_random_frames();
    int unsigned stop_at;
    stop_at = bytes_sent + RandomItems;
    while (bytes_sent < stop_at) begin
      send_random_packet();
    end
  endtask

  // frames with no idling at all on either side
  task automatic test_back_to_back();
    send_idle_on = 1'b0;
    line_idle_on = 1'b0;
    repeat (12) send_random_packet();
    send_idle_on = 1'b1;
    line_idle_on = 1'b1;
  endtask

  // reset, tests in turn, drain and verdict
  initial begin
    mismatch_count = 0;
    bytes_sent     = 0;
    quiet_cycles   = 0;
    send_idle_on   = 1'b1;
    line_idle_on   = 1'b1;
    pred_frame_open = 1'b0;
    pred_crc        = CRC_INIT;
    rst_ni           <= 1'b0;
    pkt_if.valid     <= 1'b0;
    pkt_if.data_byte <= 8'h00;
    pkt_if.last_byte <= 1'b0;
    line_if.ready    <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_escape_codes();
    test_multi_byte_frame();
    test_crc_trailer();
    test_back_to_back();
    test_random_frames();
    test_back_to_back();

    pkt_if.valid <= 1'b0;
    while (line_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && line_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
